// ===== design/dops_pkg.sv =====
package dops_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned BankCountDefault = 8;
  localparam int unsigned BurstCyclesDefault = 4;
  localparam int unsigned CommandSpacingDefault = 4;
  localparam int unsigned ClockRatioDefault = 4;

  localparam int unsigned TurnGap = 2;
  localparam logic [7:0] TimerMax = 8'd255;

  typedef enum logic [2:0] {
    K_ACT    = 3'd0,
    K_PRE    = 3'd1,
    K_RD     = 3'd2,
    K_WR     = 3'd3,
    K_ACCEPT = 3'd4,
    K_FULL   = 3'd5,
    K_ORDER  = 3'd6,
    K_DONE   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_PRECHARGED = 2'd1,
    PH_ACTIVATED  = 2'd2,
    PH_DATA       = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    REG_RCD = 3'd0,
    REG_CL  = 3'd1,
    REG_RP  = 3'd2,
    REG_RAS = 3'd3,
    REG_WL  = 3'd4,
    REG_WR  = 3'd5,
    REG_WTR = 3'd6,
    REG_RTP = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [5:0] rcd;
    logic [5:0] cl;
    logic [5:0] rp;
    logic [5:0] ras;
    logic [5:0] wl;
    logic [5:0] wr;
    logic [5:0] wtr;
    logic [5:0] rtp;
  } timing_t;

  typedef struct packed {
    logic [13:0] row;
    logic [10:0] column;
    logic [2:0]  bank;
    logic        write;
    logic [31:0] arrival;
  } entry_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  bank;
    logic [13:0] row_or_column;
    logic [33:0] issue_time;
    logic [4:0]  queue_count;
  } result_t;

  // one front-to-back word: a request or a tick
  typedef struct packed {
    logic   tick;
    entry_t entry;
    logic   accept;
    kind_t  kind;
  } job_t;

endpackage

// ===== design/dops_front.sv =====
module dops_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [65:0]      in_data,
  output logic             job_valid,
  input  logic             job_ready,
  output dops_pkg::job_t   job
);
  import dops_pkg::*;

  job_t       hold;
  logic       full;
  logic [31:0] addr;

  assign addr = in_data[32:1];
  assign in_ready = !full || job_ready;
  assign job_valid = full;
  assign job = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold.tick <= in_data[0];
      hold.entry.row <= addr[30:17];
      hold.entry.column <= addr[13:3];
      hold.entry.bank <= addr[16:14];
      hold.entry.write <= in_data[33];
      hold.entry.arrival <= in_data[65:34];
      hold.accept <= 1'b0;
      hold.kind <= K_ACCEPT;
    end
  end

endmodule

// ===== design/dops_back.sv =====
module dops_back #(
  parameter int unsigned QUEUE_DEPTH = dops_pkg::QueueDepthDefault,
  parameter int unsigned BURST_CYCLES = dops_pkg::BurstCyclesDefault,
  parameter int unsigned COMMAND_SPACING = dops_pkg::CommandSpacingDefault,
  parameter int unsigned CLOCK_RATIO = dops_pkg::ClockRatioDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  dops_pkg::timing_t tm,
  input  logic              job_valid,
  output logic              job_ready,
  input  dops_pkg::job_t    job,
  output logic              res_valid,
  input  logic              res_ready,
  output dops_pkg::result_t res
);
  import dops_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t            store [QUEUE_DEPTH];
  logic [PtrW-1:0]   head_pointer, tail_pointer;
  logic [PtrW-1:0]   head_inc;
  logic [CntW-1:0]   entry_count;
  logic [31:0]       last_arrival;
  logic [7:0]        open_valid;
  logic [13:0]       open_row [8];
  logic [31:0]       activate_stamp [8];
  logic [31:0]       read_stamp [8];
  logic [31:0]       write_stamp [8];
  logic [31:0]       dram_time;
  phase_t            head_phase, head_phase_next;
  logic [7:0]        phase_timer;

  entry_t            hd;
  logic [2:0]        b;
  logic [31:0]       age_a, age_r, age_w;
  logic              emit;
  result_t           r;
  logic              do_act, do_pre, do_acc, do_done;
  logic              fire;
  logic signed [8:0] thr;
  logic [35:0]       now_cpu;

  assign b = hd.bank;
  assign head_inc = (head_pointer == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_pointer + 1'b1;
  assign age_a = dram_time - activate_stamp[b];
  assign age_r = dram_time - read_stamp[b];
  assign age_w = dram_time - write_stamp[b];
  assign thr = 9'(tm.cl) + 9'(BURST_CYCLES + TurnGap) - 9'(tm.wl);
  assign now_cpu = 36'(dram_time) * 36'(CLOCK_RATIO);

  assign job_ready = !res_valid || res_ready;
  assign fire = job_valid && job_ready;

  // the head is due once dram_time times CLOCK_RATIO has reached its arrival
  always_comb begin
    head_phase_next = head_phase;
    do_act = 1'b0;
    do_pre = 1'b0;
    do_acc = 1'b0;
    do_done = 1'b0;
    if (entry_count != '0 && now_cpu >= 36'(hd.arrival)) begin
      unique case (head_phase)
        PH_IDLE: begin
          if (!open_valid[b]) begin
            do_act = 1'b1;
          end else if (open_row[b] != hd.row) begin
            do_pre = (age_a >= 32'(tm.ras)) && (age_r >= 32'(tm.rtp)) &&
                     ({1'b0, age_w} >= 33'(tm.wl) + 33'(BURST_CYCLES) + 33'(tm.wr));
          end else if (hd.write) begin
            do_acc = (age_w >= 32'(COMMAND_SPACING)) &&
                     (thr <= 0 || age_r >= 32'(unsigned'(thr)));
          end else begin
            do_acc = (age_r >= 32'(COMMAND_SPACING)) &&
                     ({1'b0, age_w} >= 33'(tm.wl) + 33'(BURST_CYCLES) + 33'(tm.wtr));
          end
        end
        PH_PRECHARGED: do_act = phase_timer >= 8'(tm.rp);
        PH_ACTIVATED:  do_acc = phase_timer >= 8'(tm.rcd);
        PH_DATA: do_done = 9'(phase_timer) >=
                           9'(hd.write ? tm.wl : tm.cl) + 9'(BURST_CYCLES);
        default: ;
      endcase
    end
    if (do_act) head_phase_next = PH_ACTIVATED;
    if (do_pre) head_phase_next = PH_PRECHARGED;
    if (do_acc) head_phase_next = PH_DATA;
    if (do_done) head_phase_next = PH_IDLE;
  end

  always_comb begin
    emit = 1'b1;
    r.bank = job.entry.bank;
    r.row_or_column = '0;
    r.issue_time = now_cpu[33:0];
    r.queue_count = 5'(entry_count);
    r.kind = K_ACCEPT;
    if (!job.tick) begin
      if (entry_count >= CntW'(QUEUE_DEPTH)) begin
        r.kind = K_FULL;
      end else if (job.entry.arrival < last_arrival) begin
        r.kind = K_ORDER;
      end else begin
        r.queue_count = 5'(entry_count + 1'b1);
      end
    end else begin
      r.bank = b;
      emit = do_act || do_pre || do_acc || do_done;
      if (do_act) begin
        r.kind = K_ACT;
        r.row_or_column = hd.row;
      end else if (do_pre) begin
        r.kind = K_PRE;
      end else if (do_acc) begin
        r.kind = hd.write ? K_WR : K_RD;
        r.row_or_column = {3'b000, hd.column};
      end else begin
        r.kind = K_DONE;
        r.queue_count = 5'(entry_count - 1'b1);
      end
    end
  end

  // head register: load the first word into an empty queue, advance on completion
  always_ff @(posedge clk) begin
    if (fire && !job.tick && r.kind == K_ACCEPT && entry_count == '0) begin
      hd <= job.entry;
    end else if (fire && job.tick && do_done) begin
      hd <= store[head_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      head_pointer <= '0;
      tail_pointer <= '0;
      entry_count <= '0;
      last_arrival <= '0;
      open_valid <= '0;
      dram_time <= '0;
      head_phase <= PH_IDLE;
      phase_timer <= '0;
      for (int i = 0; i < 8; i++) begin
        activate_stamp[i] <= '0;
        read_stamp[i] <= '0;
        write_stamp[i] <= '0;
      end
    end else begin
      if (fire) begin
        res_valid <= emit;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (fire) begin
        res <= r;
        if (!job.tick) begin
          if (r.kind == K_ACCEPT) begin
            store[tail_pointer] <= job.entry;
            tail_pointer <= (tail_pointer == PtrW'(QUEUE_DEPTH - 1)) ? '0
                            : tail_pointer + 1'b1;
            entry_count <= entry_count + 1'b1;
            last_arrival <= job.entry.arrival;
          end
        end else begin
          head_phase <= head_phase_next;
          if (emit) begin
            phase_timer <= 8'd1;
          end else if (phase_timer < TimerMax) begin
            phase_timer <= phase_timer + 1'b1;
          end
          dram_time <= dram_time + 1'b1;
          if (do_act) begin
            open_valid[b] <= 1'b1;
            open_row[b] <= hd.row;
            activate_stamp[b] <= dram_time;
          end
          if (do_pre) open_valid[b] <= 1'b0;
          if (do_acc) begin
            if (hd.write) write_stamp[b] <= dram_time;
            else read_stamp[b] <= dram_time;
          end
          if (do_done) begin
            head_pointer <= head_inc;
            entry_count <= entry_count - 1'b1;
          end
        end
      end
    end
  end

  logic unused;
  assign unused = ^{job.accept, job.kind};

endmodule

// ===== design/dram_open_page_command_scheduler_top.sv =====
// A word is registered in the front part and its result in the back part before the result port.
// Throughput: one word per cycle while the result side takes each result.
// The rate is set by the single-cycle head step in the back part.
// Reset (rst, synchronous, active high) empties the queue, closes all banks,
// zeroes the time and stamps and loads the default timing registers.
module dram_open_page_command_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = dops_pkg::QueueDepthDefault,
  parameter int unsigned BURST_CYCLES = dops_pkg::BurstCyclesDefault,
  parameter int unsigned COMMAND_SPACING = dops_pkg::CommandSpacingDefault,
  parameter int unsigned CLOCK_RATIO = dops_pkg::ClockRatioDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // address, is_write, arrival_time, zero pad
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // kind, bank, row_or_column, issue_time, queue_count, pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dops_pkg::*;

  timing_t tm;
  job_t    job;
  logic    job_valid, job_ready;
  result_t res;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      tm <= '{rcd: 6'd14, cl: 6'd14, rp: 6'd14, ras: 6'd36,
              wl: 6'd10, wr: 6'd16, wtr: 6'd8, rtp: 6'd8};
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_idx_t'(ridx))
        REG_RCD: tm.rcd <= pwdata[5:0];
        REG_CL:  tm.cl  <= pwdata[5:0];
        REG_RP:  tm.rp  <= pwdata[5:0];
        REG_RAS: tm.ras <= pwdata[5:0];
        REG_WL:  tm.wl  <= pwdata[5:0];
        REG_WR:  tm.wr  <= pwdata[5:0];
        REG_WTR: tm.wtr <= pwdata[5:0];
        REG_RTP: tm.rtp <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(ridx))
      REG_RCD: prdata[5:0] = tm.rcd;
      REG_CL:  prdata[5:0] = tm.cl;
      REG_RP:  prdata[5:0] = tm.rp;
      REG_RAS: prdata[5:0] = tm.ras;
      REG_WL:  prdata[5:0] = tm.wl;
      REG_WR:  prdata[5:0] = tm.wr;
      REG_WTR: prdata[5:0] = tm.wtr;
      REG_RTP: prdata[5:0] = tm.rtp;
      default: ;
    endcase
    if (paddr[1:0] != 2'b00) prdata = '0;
  end

  dops_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_data({s_tdata[64:33], s_tdata[32], s_tdata[31:0], s_tuser}),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  dops_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .BURST_CYCLES(BURST_CYCLES),
    .COMMAND_SPACING(COMMAND_SPACING), .CLOCK_RATIO(CLOCK_RATIO)
  ) u_back (
    .clk(clk), .rst(rst), .tm(tm),
    .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
  );

  assign m_tdata = {5'b0, res.queue_count, res.issue_time, res.row_or_column,
                    res.bank, res.kind};

  logic unused;
  assign unused = ^{s_tdata[71:65], pwdata[31:6]};

endmodule

// ===== design/dops_checker.sv =====
module dops_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        pready
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[58:54] <= 5'd16)
    else $error("count too large");
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid && s_tready)
    else $error("bad state after reset");
endmodule

bind dram_open_page_command_scheduler_top dops_checker u_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);

// ===== tb/sv/dram_open_page_command_scheduler_top_tb.sv =====
module dram_open_page_command_scheduler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dops_pkg::*;

  localparam int unsigned Depth = QueueDepthDefault;
  localparam int unsigned Burst = BurstCyclesDefault;
  localparam int unsigned Spacing = CommandSpacingDefault;
  localparam int unsigned Ratio = ClockRatioDefault;
  localparam logic [14:0] RowClosed = 15'h4000;
  localparam int WatchdogLimit = 4000;

  typedef struct {
    bit          tick;
    logic [31:0] address;
    bit          is_write;
    logic [31:0] arrival;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dram_open_page_command_scheduler_top u_top (.*);

  always #5 clk = ~clk;

  // scheduler image
  logic [5:0]  tm_rcd, tm_cl, tm_rp, tm_ras, tm_wl, tm_wr, tm_wtr, tm_rtp;
  entry_t      sched_store[Depth];
  int unsigned sched_head, sched_tail, sched_count;
  logic [31:0] sched_last_arrival;
  logic [14:0] bank_row[8];
  logic [31:0] act_stamp[8], rd_stamp[8], wr_stamp[8];
  logic [31:0] model_time;
  phase_t      head_state;
  logic [7:0]  head_timer;

  word_t   pending_words[$];
  result_t expected_results[$];
  int      fail_count = 0;
  int      result_count = 0;
  int      accepted_words = 0;
  int      kind_seen[8];
  bit      idle_on = 1'b1;
  int      hold_request = 0;
  int      stall_cycles = 0;

  function automatic void record(kind_t k, logic [2:0] b, logic [13:0] rc);
    result_t r;
    r.kind = k;
    r.bank = b;
    r.row_or_column = rc;
    r.issue_time = 34'(model_time) * Ratio;
    r.queue_count = 5'(sched_count);
    expected_results.push_back(r);
  endfunction

  function automatic logic [31:0] stamp_age(logic [31:0] s);
    return model_time - s;
  endfunction

  function automatic void open_bank(entry_t e);
    bank_row[e.bank] = {1'b0, e.row};
    act_stamp[e.bank] = model_time;
    head_state = PH_ACTIVATED;
    head_timer = 0;
    record(K_ACT, e.bank, e.row);
  endfunction

  function automatic void access_bank(entry_t e);
    if (e.write) wr_stamp[e.bank] = model_time;
    else rd_stamp[e.bank] = model_time;
    head_state = PH_DATA;
    head_timer = 0;
    record(e.write ? K_WR : K_RD, e.bank, 14'(e.column));
  endfunction

  function automatic void advance_head();
    entry_t e;
    logic [2:0] b;
    longint unsigned due;
    int thr;
    bit ok;
    e = sched_store[sched_head];
    b = e.bank;
    due = (longint'(e.arrival) + Ratio - 1) / Ratio;
    if (longint'(model_time) < due) return;
    case (head_state)
      PH_IDLE: begin
        if (bank_row[b] == RowClosed) begin
          open_bank(e);
        end else if (bank_row[b] != {1'b0, e.row}) begin
          if (stamp_age(act_stamp[b]) >= tm_ras && stamp_age(rd_stamp[b]) >= tm_rtp &&
              longint'(stamp_age(wr_stamp[b])) >= longint'(tm_wl) + Burst + tm_wr) begin
            bank_row[b] = RowClosed;
            head_state = PH_PRECHARGED;
            head_timer = 0;
            record(K_PRE, b, '0);
          end
        end else if (e.write) begin
          thr = int'(tm_cl) + Burst + TurnGap - int'(tm_wl);
          ok = thr <= 0 || longint'(stamp_age(rd_stamp[b])) >= thr;
          if (stamp_age(wr_stamp[b]) >= Spacing && ok) access_bank(e);
        end else begin
          if (stamp_age(rd_stamp[b]) >= Spacing &&
              longint'(stamp_age(wr_stamp[b])) >= longint'(tm_wl) + Burst + tm_wtr)
            access_bank(e);
        end
      end
      PH_PRECHARGED: if (head_timer >= tm_rp) open_bank(e);
      PH_ACTIVATED: if (head_timer >= tm_rcd) access_bank(e);
      default: begin
        if (int'(head_timer) >= int'(e.write ? tm_wl : tm_cl) + Burst) begin
          sched_head = (sched_head + 1) % Depth;
          sched_count--;
          head_state = PH_IDLE;
          head_timer = 0;
          record(K_DONE, b, '0);
        end
      end
    endcase
  endfunction

  function automatic void schedule_word(word_t w);
    entry_t e;
    logic [2:0] b;
    b = w.address[16:14];
    if (!w.tick) begin
      if (sched_count >= Depth) begin
        record(K_FULL, b, '0);
      end else if (w.arrival < sched_last_arrival) begin
        record(K_ORDER, b, '0);
      end else begin
        e.row = w.address[30:17];
        e.column = w.address[13:3];
        e.bank = b;
        e.write = w.is_write;
        e.arrival = w.arrival;
        sched_store[sched_tail] = e;
        sched_tail = (sched_tail + 1) % Depth;
        sched_count++;
        sched_last_arrival = w.arrival;
        record(K_ACCEPT, b, '0);
      end
    end else begin
      if (sched_count > 0) advance_head();
      if (head_timer < TimerMax) head_timer++;
      model_time++;
    end
    pending_words.push_back(w);
  endfunction

  function automatic void reset_image();
    tm_rcd = 14; tm_cl = 14; tm_rp = 14; tm_ras = 36;
    tm_wl = 10; tm_wr = 16; tm_wtr = 8; tm_rtp = 8;
    sched_head = 0; sched_tail = 0; sched_count = 0; sched_last_arrival = 0;
    for (int i = 0; i < 8; i++) begin
      bank_row[i] = RowClosed;
      act_stamp[i] = 0;
      rd_stamp[i] = 0;
      wr_stamp[i] = 0;
    end
    model_time = 0;
    head_state = PH_IDLE;
    head_timer = 0;
  endfunction

  function automatic void add_request(logic [31:0] a, bit wr, logic [31:0] t);
    word_t w;
    w.tick = 1'b0;
    w.address = a;
    w.is_write = wr;
    w.arrival = t;
    schedule_word(w);
  endfunction

  function automatic void add_tick();
    word_t w;
    w.tick = 1'b1;
    w.address = $urandom;
    w.is_write = $urandom_range(0, 1);
    w.arrival = $urandom;
    schedule_word(w);
  endfunction

  // mostly well-formed traffic: arrivals near the current time, page hits, some bursts to fill the queue
  function automatic void add_traffic(int n);
    logic [31:0] prev_addr, a, t;
    int burst;
    prev_addr = $urandom;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0 && $urandom_range(0, 39) == 0) burst = $urandom_range(8, 20);
      if (burst > 0 || $urandom_range(0, 9) < 3) begin
        if (burst > 0) burst--;
        case ($urandom_range(0, 3))
          0: a = $urandom;
          1: a = {prev_addr[31:17], 3'($urandom_range(0, 7)), 14'($urandom)};
          default: a = {prev_addr[31:14], 14'($urandom)};
        endcase
        if (sched_last_arrival > 0 && $urandom_range(0, 9) == 0)
          t = $urandom_range(0, sched_last_arrival - 1);
        else if (longint'(model_time) * Ratio > longint'(sched_last_arrival))
          t = model_time * Ratio + $urandom_range(0, 60);
        else
          t = sched_last_arrival + $urandom_range(0, 60);
        prev_addr = a;
        add_request(a, $urandom_range(0, 1), t);
      end else begin
        add_tick();
      end
    end
  endfunction

  task automatic write_timing(reg_idx_t idx, logic [5:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RCD: tm_rcd = v;
      REG_CL:  tm_cl = v;
      REG_RP:  tm_rp = v;
      REG_RAS: tm_ras = v;
      REG_WL:  tm_wl = v;
      REG_WR:  tm_wr = v;
      REG_WTR: tm_wtr = v;
      default: tm_rtp = v;
    endcase
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && expected_results.size() == 0 && !s_tvalid);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_all(int lo, int hi);
    for (int r = 0; r < 8; r++) write_timing(reg_idx_t'(r), 6'($urandom_range(lo, hi)));
  endtask

  // sender
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        void'(pending_words.pop_front());
        accepted_words++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 12);
          s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tuser <= pending_words[0].tick;
          s_tdata <= {7'b0, pending_words[0].arrival, pending_words[0].is_write,
                      pending_words[0].address};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  int recv_gap = 0;
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind = kind_t'(m_tdata[2:0]);
        got.bank = m_tdata[5:3];
        got.row_or_column = m_tdata[19:6];
        got.issue_time = m_tdata[53:20];
        got.queue_count = m_tdata[58:54];
        result_count++;
        kind_seen[got.kind]++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, m_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.kind != want.kind || got.bank != want.bank ||
              got.row_or_column != want.row_or_column ||
              got.issue_time != want.issue_time || got.queue_count != want.queue_count) begin
            $display("%0t: mismatch expected kind %0d bank %0d rc %0d time %0d count %0d",
                     $time, want.kind, want.bank, want.row_or_column, want.issue_time,
                     want.queue_count);
            $display("%0t:            actual kind %0d bank %0d rc %0d time %0d count %0d",
                     $time, got.kind, got.bank, got.row_or_column, got.issue_time,
                     got.queue_count);
            fail_count++;
          end
        end
      end
      if (hold_request > 0) begin
        stall_cycles = hold_request;
        hold_request = 0;
      end
      if (stall_cycles > 0) begin
        stall_cycles--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(0, 12);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with work outstanding but no word moving
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst && (pending_words.size() > 0 || expected_results.size() > 0) &&
        !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("Regression FAIL");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  initial begin
    reset_image();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: quiet tick, field extremes, fill the queue, full reject with top values
    add_tick();
    add_request(32'h0000_0000, 1'b0, 32'd0);
    add_request(32'hFFFF_FFFF, 1'b1, 32'd0);
    add_request(32'h0000_4000, 1'b1, 32'd0);
    add_request(32'h0002_0000, 1'b0, 32'd1);
    for (int i = 0; i < 12; i++) add_request($urandom, i[0], 32'd1);
    add_request(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    add_request(32'h0000_0000, 1'b0, 32'h8000_0000);
    add_traffic(140);
    drain();

    set_all(1, 1);
    hold_request = 250;
    add_traffic(170);
    drain();

    set_all(63, 63);
    add_traffic(170);
    drain();

    set_all(1, 63);
    add_traffic(160);
    drain();

    set_all(1, 12);
    add_traffic(160);
    drain();

    write_timing(REG_CL, 6'd1);
    write_timing(REG_WL, 6'd63);
    idle_on = 1'b0;
    add_traffic(130);
    drain();

    $display("Covered %0d words, %0d results: ACT %0d PRE %0d RD %0d WR %0d done %0d",
             accepted_words, result_count, kind_seen[K_ACT], kind_seen[K_PRE],
             kind_seen[K_RD], kind_seen[K_WR], kind_seen[K_DONE]);
    $display("Requests accepted %0d, full rejects %0d, order rejects %0d, six timing sets",
             kind_seen[K_ACCEPT], kind_seen[K_FULL], kind_seen[K_ORDER]);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
